FILE: rtl/adsr_pkg.sv
// Shared types, constants and helper functions of the ADSR envelope and VCA.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package adsr_pkg;

  // Envelope shape.
  localparam int unsigned STEPS_PER_STAGE = 100;
  localparam int unsigned SAMPLE_BITS     = 12;

  // Widths of the fixed fields and registers.
  localparam int unsigned SMP_PORT_W = 12;
  localparam int unsigned SMP_W      = (SAMPLE_BITS < SMP_PORT_W) ? SAMPLE_BITS : SMP_PORT_W;
  localparam int unsigned LVL_W      = 17;
  localparam int unsigned MS_W       = 11;
  localparam int unsigned SUS_W      = 11;
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned PHC_W      = 3;
  localparam int unsigned DATA_W     = 32;

  localparam int unsigned UNIT_STEP  = 1024;
  localparam int unsigned UNIT_SHIFT = $clog2(UNIT_STEP);
  localparam int unsigned FULL_LEVEL = UNIT_STEP * STEPS_PER_STAGE;
  localparam int unsigned LAST_STEP  = STEPS_PER_STAGE - 1;
  localparam int unsigned IDX_W      = $clog2(STEPS_PER_STAGE);
  localparam int unsigned MS_MAX     = (1 << MS_W) - 1;
  localparam int unsigned DUR_W      = $clog2(MS_MAX / STEPS_PER_STAGE + 1);

  // Division by STEPS_PER_STAGE as a multiplication by a rounded-up reciprocal.
  // Exact for every dividend below 2**(RECIP_SHIFT - 7).
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 33;
  localparam logic [63:0] RECIP64 =
      ((64'd1 << RECIP_SHIFT) + 64'(STEPS_PER_STAGE) - 64'd1) / 64'(STEPS_PER_STAGE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

  // Scaled sample after the shift by UNIT_SHIFT: below 2**SMP_W * STEPS_PER_STAGE.
  localparam int unsigned Y_W = SMP_W + $clog2(STEPS_PER_STAGE);

  // Register map.
  localparam int unsigned NUM_REGS = 5;
  localparam int unsigned ADDR_W   = $clog2(NUM_REGS * 4);
  localparam int unsigned RIDX_W   = ADDR_W - 2;

  typedef enum logic [RIDX_W-1:0] {
    REG_ATTACK   = RIDX_W'(0),
    REG_DECAY    = RIDX_W'(1),
    REG_SUSTAIN  = RIDX_W'(2),
    REG_RELEASE  = RIDX_W'(3),
    REG_DEBOUNCE = RIDX_W'(4)
  } reg_idx_e;

  localparam logic [SUS_W-1:0] SUSTAIN_RESET  = SUS_W'(1024);
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);

  // Envelope phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_DEBOUNCE = 6'b000010,
    PH_ATTACK   = 6'b000100,
    PH_DECAY    = 6'b001000,
    PH_SUSTAIN  = 6'b010000,
    PH_RELEASE  = 6'b100000
  } phase_e;

  // Phase codes as seen on the result port.
  localparam logic [PHC_W-1:0] PHC_IDLE     = 3'd0;
  localparam logic [PHC_W-1:0] PHC_DEBOUNCE = 3'd1;
  localparam logic [PHC_W-1:0] PHC_ATTACK   = 3'd2;
  localparam logic [PHC_W-1:0] PHC_DECAY    = 3'd3;
  localparam logic [PHC_W-1:0] PHC_SUSTAIN  = 3'd4;
  localparam logic [PHC_W-1:0] PHC_RELEASE  = 3'd5;

  typedef struct packed {
    logic [DUR_W-1:0] attack_dur;
    logic [DUR_W-1:0] decay_dur;
    logic [DUR_W-1:0] release_dur;
    logic [SUS_W-1:0] sustain;
    logic [DEB_W-1:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             gate;
    logic             tick;
  } item_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic [LVL_W-1:0] level;
    logic [PHC_W-1:0] phase;
  } env_out_t;

  typedef struct packed {
    logic [SMP_PORT_W-1:0] dac;
    logic [LVL_W-1:0]      level;
    logic [PHC_W-1:0]      phase;
  } res_t;

  function automatic logic [DUR_W-1:0] div_steps(input logic [MS_W-1:0] ms);
    logic [MS_W+RECIP_W-1:0] prod;
    prod = (MS_W + RECIP_W)'(ms) * (MS_W + RECIP_W)'(RECIP);
    return DUR_W'(prod >> RECIP_SHIFT);
  endfunction

  function automatic logic [PHC_W-1:0] phase_code(input phase_e ph);
    logic [PHC_W-1:0] code;
    case (ph)
      PH_IDLE:     code = PHC_IDLE;
      PH_DEBOUNCE: code = PHC_DEBOUNCE;
      PH_ATTACK:   code = PHC_ATTACK;
      PH_DECAY:    code = PHC_DECAY;
      PH_SUSTAIN:  code = PHC_SUSTAIN;
      PH_RELEASE:  code = PHC_RELEASE;
      default:     code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/adsr_regs.sv
// Configuration registers of the ADSR envelope behind an APB-style port.
// Depends on adsr_pkg; step durations are worked out when a register is written.
`default_nettype none

module adsr_regs
  import adsr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [MS_W-1:0]  attack_q, decay_q, release_q;
  logic [SUS_W-1:0] sustain_q;
  logic [DEB_W-1:0] debounce_q;
  logic [DUR_W-1:0] attack_dur_q, decay_dur_q, release_dur_q;
  logic             wr_en;
  logic [RIDX_W-1:0] idx;
  logic [DUR_W-1:0] wr_dur;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_dur = div_steps(pwdata[MS_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q      <= '0;
      decay_q       <= '0;
      sustain_q     <= SUSTAIN_RESET;
      release_q     <= '0;
      debounce_q    <= DEBOUNCE_RESET;
      attack_dur_q  <= '0;
      decay_dur_q   <= '0;
      release_dur_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_ATTACK: begin
          attack_q     <= pwdata[MS_W-1:0];
          attack_dur_q <= wr_dur;
        end
        REG_DECAY: begin
          decay_q     <= pwdata[MS_W-1:0];
          decay_dur_q <= wr_dur;
        end
        REG_SUSTAIN: begin
          sustain_q <= pwdata[SUS_W-1:0];
        end
        REG_RELEASE: begin
          release_q     <= pwdata[MS_W-1:0];
          release_dur_q <= wr_dur;
        end
        REG_DEBOUNCE: begin
          debounce_q <= pwdata[DEB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTACK:   prdata = DATA_W'(attack_q);
      REG_DECAY:    prdata = DATA_W'(decay_q);
      REG_SUSTAIN:  prdata = DATA_W'(sustain_q);
      REG_RELEASE:  prdata = DATA_W'(release_q);
      REG_DEBOUNCE: prdata = DATA_W'(debounce_q);
      default:      prdata = '0;
    endcase
  end

  // Sustain values above full scale count as full scale.
  always_comb begin
    cfg_o.attack_dur  = attack_dur_q;
    cfg_o.decay_dur   = decay_dur_q;
    cfg_o.release_dur = release_dur_q;
    cfg_o.debounce    = debounce_q;
    cfg_o.sustain     = (sustain_q > SUS_W'(UNIT_STEP)) ? SUS_W'(UNIT_STEP) : sustain_q;
  end

endmodule

`default_nettype wire

FILE: rtl/adsr_front.sv
// Front end: accepts input items into a two-entry queue and trims the sample.
// Depends on adsr_pkg.
`default_nettype none

module adsr_front
  import adsr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [SMP_PORT_W-1:0] sample_in_i,
  input  wire logic                  gate_level_i,
  input  wire logic                  ms_tick_i,
  output item_t                      item_o,
  output logic                       item_valid_o,
  input  wire logic                  item_take_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;
  item_t       wr_item;

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr           = push_i & ~full_o;
  assign rd           = item_take_i & item_valid_o;

  // Only the low sample bits take part in the scaling.
  always_comb begin
    wr_item.sample = sample_in_i[SMP_W-1:0];
    wr_item.gate   = gate_level_i;
    wr_item.tick   = ms_tick_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({wr, rd})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/adsr_env.sv
// Envelope sequencer: phase, level, step and debounce counters, one item a cycle
// while room_i is high. Depends on adsr_pkg; fed by adsr_front, feeds adsr_vca.
`default_nettype none

module adsr_env
  import adsr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire item_t item_i,
  input  wire logic  item_valid_i,
  input  wire logic  room_i,
  output logic       item_take_o,
  output env_out_t   env_o,
  output logic       env_valid_o
);

  localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(FULL_LEVEL);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST_STEP);
  localparam logic [LVL_W-1:0] UNIT_LVL = LVL_W'(UNIT_STEP);

  phase_e           phase_q, phase_d;
  logic [LVL_W-1:0] level_q, level_d, level_nx;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [DUR_W-1:0] ticks_q, ticks_d, ticks_n;
  logic [DEB_W-1:0] deb_q, deb_d;
  env_out_t         env_q;
  logic             env_valid_q;

  logic [DUR_W-1:0]       dur;
  logic [DUR_W:0]         ticks_inc;
  logic                   step_over;
  logic [DEB_W:0]         deb_inc;
  logic                   deb_hit;
  logic [SUS_W-1:0]       dec;
  logic [IDX_W-1:0]       rel_fac;
  logic [SUS_W+IDX_W-1:0] rel_prod;
  logic                   take;

  assign take        = item_valid_i & room_i;
  assign item_take_o = take;

  // Step timer of the running stage.
  always_comb begin
    case (phase_q)
      PH_ATTACK: dur = cfg_i.attack_dur;
      PH_DECAY:  dur = cfg_i.decay_dur;
      default:   dur = cfg_i.release_dur;
    endcase
    ticks_inc = (DUR_W + 1)'(ticks_q) + (DUR_W + 1)'(1);
    if (dur == '0) begin
      step_over = 1'b1;
      ticks_n   = '0;
    end else if (item_i.tick && (ticks_inc >= (DUR_W + 1)'(dur))) begin
      step_over = 1'b1;
      ticks_n   = '0;
    end else begin
      step_over = 1'b0;
      ticks_n   = item_i.tick ? ticks_inc[DUR_W-1:0] : ticks_q;
    end
  end

  assign deb_inc = (DEB_W + 1)'(deb_q) + (DEB_W + 1)'(1);
  assign deb_hit = deb_inc >= (DEB_W + 1)'(cfg_i.debounce);
  assign dec     = SUS_W'(UNIT_STEP) - cfg_i.sustain;

  // One multiplier serves both the entry into release and each release step.
  assign rel_fac  = (phase_q == PH_RELEASE) ? (LAST_IDX - idx_q) : LAST_IDX;
  assign rel_prod = (SUS_W + IDX_W)'(cfg_i.sustain) * (SUS_W + IDX_W)'(rel_fac);

  always_comb begin
    phase_d  = phase_q;
    level_nx = level_q;
    idx_d    = idx_q;
    ticks_d  = ticks_q;
    deb_d    = deb_q;
    case (phase_q)
      PH_IDLE: begin
        level_nx = '0;
        if (item_i.gate) begin
          if (cfg_i.debounce == '0) begin
            phase_d  = PH_ATTACK;
            idx_d    = IDX_W'(1);
            ticks_d  = '0;
            deb_d    = '0;
            level_nx = UNIT_LVL;
          end else begin
            phase_d = PH_DEBOUNCE;
            deb_d   = '0;
          end
        end
      end
      PH_DEBOUNCE: begin
        level_nx = '0;
        if (!item_i.gate) begin
          phase_d = PH_IDLE;
          deb_d   = '0;
        end else if ((cfg_i.debounce == '0) || (item_i.tick && deb_hit)) begin
          phase_d  = PH_ATTACK;
          idx_d    = IDX_W'(1);
          ticks_d  = '0;
          deb_d    = '0;
          level_nx = UNIT_LVL;
        end else if (item_i.tick) begin
          deb_d = deb_inc[DEB_W-1:0];
        end
      end
      PH_ATTACK: begin
        ticks_d = ticks_n;
        if (step_over) begin
          if (idx_q < LAST_IDX) begin
            idx_d    = idx_q + IDX_W'(1);
            level_nx = level_q + UNIT_LVL;
          end else begin
            // The jump to full scale and the first decay step share an item.
            phase_d  = PH_DECAY;
            idx_d    = IDX_W'(1);
            level_nx = FULL_LVL - LVL_W'(dec);
          end
        end
      end
      PH_DECAY: begin
        ticks_d = ticks_n;
        if (step_over) begin
          if (idx_q < LAST_IDX) begin
            idx_d    = idx_q + IDX_W'(1);
            level_nx = (level_q > LVL_W'(dec)) ? (level_q - LVL_W'(dec)) : '0;
          end else begin
            phase_d = PH_SUSTAIN;
            idx_d   = '0;
            deb_d   = '0;
          end
        end
      end
      PH_SUSTAIN: begin
        if (item_i.gate) begin
          deb_d = '0;
        end else if ((cfg_i.debounce == '0) || (item_i.tick && deb_hit)) begin
          phase_d  = PH_RELEASE;
          idx_d    = IDX_W'(1);
          ticks_d  = '0;
          deb_d    = '0;
          level_nx = LVL_W'(rel_prod);
        end else if (item_i.tick) begin
          deb_d = deb_inc[DEB_W-1:0];
        end
      end
      PH_RELEASE: begin
        ticks_d = ticks_n;
        if (step_over) begin
          if (idx_q < LAST_IDX) begin
            idx_d    = idx_q + IDX_W'(1);
            level_nx = LVL_W'(rel_prod);
          end else begin
            phase_d  = PH_IDLE;
            idx_d    = '0;
            level_nx = '0;
          end
        end
      end
      default: begin
        phase_d  = PH_IDLE;
        level_nx = '0;
      end
    endcase
    level_d = (level_nx > FULL_LVL) ? FULL_LVL : level_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      level_q     <= '0;
      idx_q       <= '0;
      ticks_q     <= '0;
      deb_q       <= '0;
      env_valid_q <= 1'b0;
    end else begin
      env_valid_q <= take;
      if (take) begin
        phase_q <= phase_d;
        level_q <= level_d;
        idx_q   <= idx_d;
        ticks_q <= ticks_d;
        deb_q   <= deb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      env_q.sample <= item_i.sample;
      env_q.level  <= level_d;
      env_q.phase  <= phase_code(phase_d);
    end
  end

  assign env_o       = env_q;
  assign env_valid_o = env_valid_q;

`ifndef SYNTHESIS
  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= FULL_LVL)
    else $error("envelope level above full scale");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_IDLE) || (phase_q == PH_DEBOUNCE)) |-> (level_q == '0))
    else $error("nonzero level outside the envelope");

  a_attack_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ATTACK) |-> (level_q == (LVL_W'(idx_q) << UNIT_SHIFT)))
    else $error("attack level does not follow the step index");
`endif

endmodule

`default_nettype wire

FILE: rtl/adsr_vca.sv
// Back end: sample times envelope, scaled to the DAC range, then the result queue.
// Depends on adsr_pkg; fed by adsr_env.
`default_nettype none

module adsr_vca
  import adsr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire env_out_t env_i,
  input  wire logic     env_valid_i,
  output logic          room_o,
  output logic          empty_o,
  input  wire logic     pop_i,
  output res_t          res_o
);

  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned SUM_W    = OQ_AW + 2;
  localparam int unsigned P_W      = SMP_W + LVL_W;
  localparam int unsigned Q_W      = Y_W + RECIP_W;

  // Stage 1: sample times level.
  logic             v1_q;
  logic [P_W-1:0]   p1_q;
  logic [LVL_W-1:0] lvl1_q;
  logic [PHC_W-1:0] ph1_q;
  // Stage 2: divide by the step count through the reciprocal.
  logic             v2_q;
  logic [Q_W-1:0]   q2_q;
  logic [LVL_W-1:0] lvl2_q;
  logic [PHC_W-1:0] ph2_q;

  logic [Y_W-1:0]   y1;
  res_t             wr_res;

  res_t             mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_AW:0]   cnt_q;
  logic             wr, rd;
  logic [SUM_W-1:0] used;

  assign y1 = p1_q[UNIT_SHIFT +: Y_W];

  always_ff @(posedge clk_i) begin
    p1_q   <= P_W'(env_i.sample) * P_W'(env_i.level);
    lvl1_q <= env_i.level;
    ph1_q  <= env_i.phase;
    q2_q   <= Q_W'(y1) * Q_W'(RECIP);
    lvl2_q <= lvl1_q;
    ph2_q  <= ph1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= env_valid_i;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    wr_res.dac   = SMP_PORT_W'(q2_q[RECIP_SHIFT +: SMP_W]);
    wr_res.level = lvl2_q;
    wr_res.phase = ph2_q;
  end

  // Room is granted against queued plus in-flight results, so the pipe never stalls.
  assign used = SUM_W'(cnt_q) + SUM_W'(env_valid_i) + SUM_W'(v1_q) + SUM_W'(v2_q);
  assign room_o  = used < SUM_W'(OQ_DEPTH);
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign wr      = v2_q;
  assign rd      = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
      end
      if (rd) begin
        rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
      end
      case ({wr, rd})
        2'b10:   cnt_q <= cnt_q + (OQ_AW + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (OQ_AW + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= SUM_W'(OQ_DEPTH))
    else $error("more results in flight than queue entries");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (cnt_q < (OQ_AW + 1)'(OQ_DEPTH)))
    else $error("result written into a full queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/adsr_envelope_vca.sv
// Top level of the linear ADSR envelope generator with sample multiplier.
// Depends on adsr_pkg, adsr_regs, adsr_front, adsr_env and adsr_vca.
//
//   Input items (sample_in_i, gate_level_i, ms_tick_i) are offered with push and
//   taken at a clock edge where push is high and full is low. Every item yields
//   exactly one result item: dac_out_o = floor(sample * level / 102400), the
//   envelope level after this item's update and the phase code.
//   Results wait in an eight-entry queue; the oldest is on the result ports while
//   empty is low and is taken at an edge where pop is high.
//   Path: a result becomes visible once its item has passed the input queue, the
//   envelope update, the multiply and the divide by the step count through a
//   reciprocal multiply. Throughput is one item per cycle while queued plus
//   in-flight results leave room in the result queue, set by the envelope update;
//   the two multiplier stages are pipelined behind it.
//   When the receiver stalls, results collect in the queue; the envelope stage
//   stops taking items once queued plus in-flight results fill the queue, then
//   the two-entry input queue fills and full rises. Nothing is dropped.
//   Reset (rst_ni low, asynchronous) empties both queues, idles the envelope at
//   level zero and loads sustain 1024, debounce 50 ms and zero durations.
//   Registers sit at byte address 4*index; write them only with nothing in flight.
`default_nettype none

module adsr_envelope_vca
  import adsr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic      [DATA_W-1:0]     prdata,
  output logic                       pready,
  // Input items
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [SMP_PORT_W-1:0] sample_in_i,
  input  wire logic                  gate_level_i,
  input  wire logic                  ms_tick_i,
  // Result items
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [SMP_PORT_W-1:0] dac_out_o,
  output logic      [LVL_W-1:0]      envelope_level_o,
  output logic      [PHC_W-1:0]      phase_out_o
);

  cfg_t     cfg;
  item_t    item;
  logic     item_valid;
  logic     item_take;
  env_out_t env_res;
  logic     env_valid;
  logic     room;
  res_t     res;

  adsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front end: accepts items and holds them until the envelope stage takes them.
  adsr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .sample_in_i  (sample_in_i),
    .gate_level_i (gate_level_i),
    .ms_tick_i    (ms_tick_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take)
  );

  // Envelope state advances once for every item it takes.
  adsr_env u_env (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_valid_i (item_valid),
    .room_i       (room),
    .item_take_o  (item_take),
    .env_o        (env_res),
    .env_valid_o  (env_valid)
  );

  // Back end: scaling pipeline and result queue; room is its credit signal.
  adsr_vca u_vca (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .env_i       (env_res),
    .env_valid_i (env_valid),
    .room_o      (room),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign dac_out_o        = res.dac;
  assign envelope_level_o = res.level;
  assign phase_out_o      = res.phase;

endmodule

`default_nettype wire
